// ----- design/frrs_pkg.sv -----
package frrs_pkg;

	localparam int unsigned IdxW   = 24;
	localparam int unsigned CountW = 16;
	localparam int unsigned CycleW = 48;
	localparam int unsigned AddrW  = 4;
	localparam int unsigned DataW  = 32;

	localparam logic [CycleW-1:0] DueMax = {CycleW{1'b1}};

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_DEFER  = 2'd1,
		REQ_TIMED  = 2'd2,
		REQ_FORCED = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_NOT_STARTED  = 2'd1,
		STATUS_NOT_DUE      = 2'd2,
		STATUS_ALL_RELEASED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_TOTAL_RESULTS    = 2'd0,
		REG_RESULTS_PER_FLOW = 2'd1,
		REG_FILL_LATENCY     = 2'd2,
		REG_FLOW_GAP         = 2'd3
	} reg_index_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [CycleW-1:0]  now_cycle;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               granted;
		logic [IdxW-1:0]    result_index;
		logic [IdxW-1:0]    released_count;
		logic               all_done;
		logic               is_started;
		logic [CycleW-1:0]  next_due_cycle;
	} rsp_t;

	typedef struct packed {
		logic [IdxW-1:0]    total_results;
		logic [CountW-1:0]  results_per_flow;
		logic [CountW-1:0]  fill_latency;
		logic [CountW-1:0]  flow_gap;
	} cfg_t;

endpackage

// ----- design/frrs_regs.sv -----
module frrs_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [frrs_pkg::AddrW-1:0] paddr,
	input  logic [frrs_pkg::DataW-1:0] pwdata,
	output logic [frrs_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output frrs_pkg::cfg_t            cfg
);
	import frrs_pkg::*;

	cfg_t       cfg_q;
	reg_index_t sel;
	logic       wr_en;

	assign sel    = reg_index_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_results    <= '0;
			cfg_q.results_per_flow <= CountW'(1);
			cfg_q.fill_latency     <= '0;
			cfg_q.flow_gap         <= '0;
		end else if (wr_en) begin
			unique case (sel)
				REG_TOTAL_RESULTS:    cfg_q.total_results    <= pwdata[IdxW-1:0];
				REG_RESULTS_PER_FLOW: cfg_q.results_per_flow <= pwdata[CountW-1:0];
				REG_FILL_LATENCY:     cfg_q.fill_latency     <= pwdata[CountW-1:0];
				REG_FLOW_GAP:         cfg_q.flow_gap         <= pwdata[CountW-1:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_TOTAL_RESULTS:    prdata = DataW'(cfg_q.total_results);
			REG_RESULTS_PER_FLOW: prdata = DataW'(cfg_q.results_per_flow);
			REG_FILL_LATENCY:     prdata = DataW'(cfg_q.fill_latency);
			REG_FLOW_GAP:         prdata = DataW'(cfg_q.flow_gap);
			default:              prdata = '0;
		endcase
	end

endmodule

// ----- design/frrs_core.sv -----
module frrs_core (
	input  logic           clk,
	input  logic           arst_n,
	input  frrs_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_ready,
	input  frrs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output frrs_pkg::rsp_t rsp
);
	import frrs_pkg::*;

	req_t               req_s1;
	logic               valid_s1;
	rsp_t               rsp_s2;
	logic               valid_s2;
	logic               adv;

	logic               started_q;
	logic [CycleW-1:0]  due_q;
	logic [IdxW-1:0]    idx_q;
	logic [CountW-1:0]  pos_q;

	logic               started_d;
	logic [CycleW-1:0]  due_d;
	logic [IdxW-1:0]    idx_d;
	logic [CountW-1:0]  pos_d;
	rsp_t               rsp_d;

	logic               done;
	logic               flow_end;
	logic [CountW:0]    step;
	logic [CycleW:0]    rel_sum;
	logic [CycleW:0]    start_sum;
	logic [CycleW-1:0]  rel_due;
	logic [CycleW-1:0]  start_due;

	assign adv       = valid_s1 & (~valid_s2 | rsp_ready);
	assign req_ready = ~valid_s1 | adv;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	assign done      = idx_q >= cfg.total_results;
	assign flow_end  = ({1'b0, pos_q} + (CountW+1)'(1)) >= {1'b0, cfg.results_per_flow};
	assign step      = flow_end ? ({1'b0, cfg.flow_gap} + (CountW+1)'(1)) : (CountW+1)'(1);
	assign rel_sum   = {1'b0, due_q} + (CycleW+1)'(step);
	assign start_sum = {1'b0, req_s1.now_cycle} + (CycleW+1)'(cfg.fill_latency);
	assign rel_due   = rel_sum[CycleW] ? DueMax : rel_sum[CycleW-1:0];
	assign start_due = start_sum[CycleW] ? DueMax : start_sum[CycleW-1:0];

	always_comb begin
		started_d            = started_q;
		due_d                = due_q;
		idx_d                = idx_q;
		pos_d                = pos_q;
		rsp_d.status         = STATUS_OK;
		rsp_d.granted        = 1'b0;
		rsp_d.result_index   = '0;
		priority if (req_s1.req_type == REQ_START) begin
			if (!started_q) begin
				started_d = 1'b1;
				due_d     = start_due;
			end
		end else if (!started_q) begin
			rsp_d.status = STATUS_NOT_STARTED;
		end else if (done) begin
			rsp_d.status = STATUS_ALL_RELEASED;
		end else if (req_s1.req_type == REQ_DEFER) begin
			if (req_s1.now_cycle > due_q) begin
				due_d = req_s1.now_cycle;
			end
		end else if (req_s1.req_type == REQ_TIMED && req_s1.now_cycle < due_q) begin
			rsp_d.status = STATUS_NOT_DUE;
		end else begin
			rsp_d.granted      = 1'b1;
			rsp_d.result_index = idx_q;
			idx_d              = idx_q + IdxW'(1);
			pos_d              = flow_end ? '0 : pos_q + CountW'(1);
			due_d              = rel_due;
		end
		rsp_d.released_count = idx_d;
		rsp_d.all_done       = idx_d >= cfg.total_results;
		rsp_d.is_started     = started_d;
		rsp_d.next_due_cycle = due_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			started_q <= 1'b0;
			due_q     <= '0;
			idx_q     <= '0;
			pos_q     <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (~valid_s2 | rsp_ready) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				started_q <= started_d;
				due_q     <= due_d;
				idx_q     <= idx_d;
				pos_q     <= pos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready & req_valid) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_s2 <= rsp_d;
		end
	end

endmodule

// ----- design/flow_result_release_scheduler.sv -----
// Release scheduler for numbered results: takes one request per clock while
// the response side keeps up and returns one response per request, in order,
// through a request register and then a response register. Throughput is one
// request per cycle, set by the schedule update (a 48-bit saturating add and
// compare) between the request register and the response register. When the
// response register is held and the request register is full, req_ready
// drops until the pending response transaction completes.
module flow_result_release_scheduler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [frrs_pkg::AddrW-1:0] paddr,
	input  logic [frrs_pkg::DataW-1:0] pwdata,
	output logic [frrs_pkg::DataW-1:0] prdata,
	output logic                       pready,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  frrs_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output frrs_pkg::rsp_t             rsp
);
	import frrs_pkg::*;

	cfg_t cfg;

	frrs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	frrs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import frrs_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic pready;

	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_item = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_item;

	cfg_t cfg_mirror;
	logic sched_started;
	logic [CycleW-1:0] sched_due;
	logic [IdxW-1:0] sched_next;
	logic [CountW-1:0] sched_pos;

	rsp_t pending_decisions[$];
	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int ready_holdoff = 0;

	flow_result_release_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		cfg_mirror.total_results = '0;
		cfg_mirror.results_per_flow = 16'd1;
		cfg_mirror.fill_latency = '0;
		cfg_mirror.flow_gap = '0;
		sched_started = 1'b0;
		sched_due = '0;
		sched_next = '0;
		sched_pos = '0;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	function automatic logic [CycleW-1:0] sat_add(input logic [CycleW-1:0] a,
			input logic [CountW:0] b);
		logic [CycleW:0] s;
		s = {1'b0, a} + {{(CycleW-CountW){1'b0}}, b};
		return s[CycleW] ? DueMax : s[CycleW-1:0];
	endfunction

	function automatic void predict_release(input req_t r);
		rsp_t e;
		logic exhausted;
		e = '0;
		e.status = STATUS_OK;
		exhausted = sched_next >= cfg_mirror.total_results;
		if (r.req_type == REQ_START) begin
			if (!sched_started) begin
				sched_started = 1'b1;
				sched_due = sat_add(r.now_cycle, {1'b0, cfg_mirror.fill_latency});
			end
		end else if (!sched_started) begin
			e.status = STATUS_NOT_STARTED;
		end else if (exhausted) begin
			e.status = STATUS_ALL_RELEASED;
		end else if (r.req_type == REQ_DEFER) begin
			if (r.now_cycle > sched_due)
				sched_due = r.now_cycle;
		end else if (r.req_type == REQ_TIMED && r.now_cycle < sched_due) begin
			e.status = STATUS_NOT_DUE;
		end else begin
			e.granted = 1'b1;
			e.result_index = sched_next;
			sched_next = sched_next + IdxW'(1);
			if ({1'b0, sched_pos} + 17'd1 >= {1'b0, cfg_mirror.results_per_flow}) begin
				sched_pos = '0;
				sched_due = sat_add(sched_due, {1'b0, cfg_mirror.flow_gap} + 17'd1);
			end else begin
				sched_pos = sched_pos + CountW'(1);
				sched_due = sat_add(sched_due, 17'd1);
			end
		end
		e.released_count = sched_next;
		e.all_done = sched_next >= cfg_mirror.total_results;
		e.is_started = sched_started;
		e.next_due_cycle = sched_due;
		pending_decisions.push_back(e);
	endfunction

	task automatic check_release(input rsp_t got);
		rsp_t want;
		if (pending_decisions.size() == 0) begin
			report_mismatch("response transaction with no request outstanding");
			return;
		end
		want = pending_decisions.pop_front();
		if (got.status !== want.status)
			report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
		if (got.granted !== want.granted)
			report_mismatch($sformatf("granted got %0b want %0b", got.granted, want.granted));
		if (got.result_index !== want.result_index)
			report_mismatch($sformatf("result_index got %0d want %0d",
				got.result_index, want.result_index));
		if (got.released_count !== want.released_count)
			report_mismatch($sformatf("released_count got %0d want %0d",
				got.released_count, want.released_count));
		if (got.all_done !== want.all_done)
			report_mismatch($sformatf("all_done got %0b want %0b", got.all_done, want.all_done));
		if (got.is_started !== want.is_started)
			report_mismatch($sformatf("is_started got %0b want %0b",
				got.is_started, want.is_started));
		if (got.next_due_cycle !== want.next_due_cycle)
			report_mismatch($sformatf("next_due_cycle got %0h want %0h",
				got.next_due_cycle, want.next_due_cycle));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_release(rsp_item);
	end

	always @(posedge clk) begin
		if (ready_holdoff > 0) begin
			rsp_ready <= 1'b0;
			ready_holdoff--;
		end else begin
			rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	function automatic req_t mk_req(input req_kind_t k, input logic [CycleW-1:0] n);
		req_t r;
		r.req_type = k;
		r.now_cycle = n;
		return r;
	endfunction

	function automatic logic [CycleW-1:0] rand_cycle();
		logic [CycleW-1:0] n;
		n[31:0] = $urandom;
		n[CycleW-1:32] = 16'($urandom);
		return n;
	endfunction

	function automatic logic [CycleW-1:0] near_due(input int off);
		logic signed [CycleW+1:0] v;
		v = $signed({2'b00, sched_due}) + off;
		if (v < 0)
			return '0;
		if (v > $signed({2'b00, DueMax}))
			return DueMax;
		return v[CycleW-1:0];
	endfunction

	task automatic issue_request(input req_t r);
		req_item <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_release(r);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_releases();
		req_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [DataW-1:0] val);
		logic [DataW-1:0] want;
		want = '0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TOTAL_RESULTS: begin
				cfg_mirror.total_results = val[IdxW-1:0];
				want = DataW'(val[IdxW-1:0]);
			end
			REG_RESULTS_PER_FLOW: begin
				cfg_mirror.results_per_flow = val[CountW-1:0];
				want = DataW'(val[CountW-1:0]);
			end
			REG_FILL_LATENCY: begin
				cfg_mirror.fill_latency = val[CountW-1:0];
				want = DataW'(val[CountW-1:0]);
			end
			REG_FLOW_GAP: begin
				cfg_mirror.flow_gap = val[CountW-1:0];
				want = DataW'(val[CountW-1:0]);
			end
			default: ;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("register %0d read got %0h want %0h",
				idx, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [IdxW-1:0] total, input logic [CountW-1:0] per_flow,
			input logic [CountW-1:0] fill, input logic [CountW-1:0] gap);
		drain_releases();
		write_reg(REG_TOTAL_RESULTS, DataW'(total));
		write_reg(REG_RESULTS_PER_FLOW, DataW'(per_flow));
		write_reg(REG_FILL_LATENCY, DataW'(fill));
		write_reg(REG_FLOW_GAP, DataW'(gap));
	endtask

	task automatic random_item();
		int pick;
		req_kind_t k;
		logic [CycleW-1:0] n;
		pick = $urandom_range(99);
		if (pick < 4)
			k = REQ_START;
		else if (pick < 24)
			k = REQ_DEFER;
		else if (pick < 70)
			k = REQ_TIMED;
		else
			k = REQ_FORCED;
		if ($urandom_range(99) < 8)
			n = rand_cycle();
		else
			n = near_due(int'($urandom_range(10)) - 4);
		issue_request(mk_req(k, n));
	endtask

	task automatic random_setting();
		logic [IdxW-1:0] total;
		logic [CountW-1:0] per_flow;
		logic [CountW-1:0] fill;
		logic [CountW-1:0] gap;
		case ($urandom_range(3))
			0: per_flow = 16'd1;
			1: per_flow = 16'hFFFF;
			default: per_flow = 16'($urandom_range(9, 2));
		endcase
		case ($urandom_range(3))
			0: gap = '0;
			1: gap = 16'hFFFF;
			default: gap = 16'($urandom_range(12, 1));
		endcase
		case ($urandom_range(3))
			0: fill = '0;
			1: fill = 16'hFFFF;
			default: fill = 16'($urandom);
		endcase
		case ($urandom_range(7))
			0: total = sched_next >> 1;
			1: total = {IdxW{1'b1}};
			default: total = sched_next + IdxW'($urandom_range(90, 20));
		endcase
		apply_setting(total, per_flow, fill, gap);
	endtask

	task automatic test_before_start();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		issue_request(mk_req(REQ_DEFER, '0));
		issue_request(mk_req(REQ_TIMED, DueMax));
		issue_request(mk_req(REQ_FORCED, rand_cycle()));
		issue_request(mk_req(REQ_TIMED, rand_cycle()));
		issue_request(mk_req(REQ_DEFER, DueMax));
		issue_request(mk_req(REQ_FORCED, '0));
	endtask

	task automatic test_first_start();
		logic [CycleW-1:0] origin;
		origin = {8'($urandom), 32'($urandom), 8'h00};
		apply_setting(24'd20, 16'd3, 16'hFFFF, 16'd2);
		issue_request(mk_req(REQ_START, origin));
		issue_request(mk_req(REQ_START, rand_cycle()));
		issue_request(mk_req(REQ_TIMED, near_due(-1)));
		issue_request(mk_req(REQ_TIMED, near_due(0)));
		issue_request(mk_req(REQ_FORCED, '0));
		issue_request(mk_req(REQ_DEFER, near_due(0)));
		issue_request(mk_req(REQ_DEFER, near_due(5)));
		issue_request(mk_req(REQ_TIMED, near_due(1)));
		issue_request(mk_req(REQ_TIMED, near_due(0)));
	endtask

	task automatic test_all_released();
		sender_idle_pct = 17;
		receiver_stall_pct = 17;
		apply_setting(sched_next, 16'd3, '0, '0);
		issue_request(mk_req(REQ_DEFER, near_due(3)));
		issue_request(mk_req(REQ_TIMED, near_due(0)));
		issue_request(mk_req(REQ_FORCED, '0));
		apply_setting('0, 16'd3, '0, '0);
		issue_request(mk_req(REQ_FORCED, near_due(2)));
		issue_request(mk_req(REQ_START, rand_cycle()));
	endtask

	task automatic test_flow_sizes();
		apply_setting(sched_next + 24'd12, '0, '0, 16'd3);
		repeat (3) issue_request(mk_req(REQ_FORCED, rand_cycle()));
		apply_setting(sched_next + 24'd12, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		issue_request(mk_req(REQ_TIMED, near_due(0)));
		issue_request(mk_req(REQ_TIMED, near_due(0)));
		issue_request(mk_req(REQ_FORCED, near_due(-3)));
	endtask

	task automatic test_backpressure();
		apply_setting(sched_next + 24'd150, 16'd4, '0, 16'd1);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		ready_holdoff = 300;
		repeat (80) random_item();
		drain_releases();
		repeat (20) random_item();
	endtask

	task automatic test_random_traffic();
		int idle_mix[4] = '{0, 64, 0, 17};
		int stall_mix[4] = '{0, 0, 64, 17};
		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 4; s++) begin
				random_setting();
				sender_idle_pct = idle_mix[p];
				receiver_stall_pct = stall_mix[p];
				repeat (100) random_item();
			end
		end
	endtask

	task automatic test_saturation();
		sender_idle_pct = 17;
		receiver_stall_pct = 17;
		apply_setting(sched_next + 24'd10, 16'd2, '0, 16'hFFFF);
		issue_request(mk_req(REQ_DEFER, DueMax - 48'd3));
		repeat (3) issue_request(mk_req(REQ_FORCED, rand_cycle()));
		issue_request(mk_req(REQ_TIMED, DueMax - 48'd1));
		issue_request(mk_req(REQ_TIMED, DueMax));
		issue_request(mk_req(REQ_DEFER, DueMax));
		issue_request(mk_req(REQ_FORCED, DueMax));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_start();
		test_first_start();
		test_all_released();
		test_flow_sizes();
		test_backpressure();
		test_random_traffic();
		test_saturation();
		drain_releases();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
